// ===== rtl/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared constants, status codes and the front-to-back request type of the
// UDP fragment reassembler.
// ----------------------------------------------------------------------------
package ufr_pkg;

  localparam int DATAGRAM_MAX = 1418;
  localparam int PACKET_BYTES = 1048576;
  localparam int HEADER_BYTES = 18;

  localparam int IDX_W   = 11;
  localparam int LEN_W   = 16;
  localparam int WORD_W  = 32;
  localparam int FILL_W  = 21;
  localparam int ADDR_W  = 20;

  localparam logic [IDX_W-1:0] INDEX_MAX     = '1;
  localparam logic [IDX_W-1:0] HDR_LAST_IDX  = IDX_W'(HEADER_BYTES - 1);
  localparam logic [IDX_W-1:0] HDR_BYTES_IDX = IDX_W'(HEADER_BYTES);
  localparam logic [IDX_W-1:0] DGRAM_MAX_IDX = IDX_W'(DATAGRAM_MAX);

  localparam logic [7:0] MAGIC_0 = 8'h46;  // F
  localparam logic [7:0] MAGIC_1 = 8'h52;  // R
  localparam logic [7:0] MAGIC_2 = 8'h4D;  // M
  localparam logic [7:0] MAGIC_3 = 8'h3A;  // :

  localparam logic [2:0] ST_PARTIAL   = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_NOT_FRAG  = 3'd2;
  localparam logic [2:0] ST_HDR_OVER  = 3'd3;
  localparam logic [2:0] ST_STAMP_BAD = 3'd4;
  localparam logic [2:0] ST_PKT_OVER  = 3'd5;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = MAGIC_0;
      2'd1:    m = MAGIC_1;
      2'd2:    m = MAGIC_2;
      default: m = MAGIC_3;
    endcase
    return m;
  endfunction

  // One classified byte, as handed from the parser to the assembler.
  typedef struct packed {
    logic [7:0]        byte_data;
    logic              last;
    logic              early;     // datagram byte before the last header byte
    logic              judge;     // last header byte: header is complete
    logic              payload;   // inside the declared payload, below the size limit
    logic [IDX_W-1:0]  offset;    // payload byte index
    logic              magic_ok;
    logic [LEN_W-1:0]  frag_length;
    logic [WORD_W-1:0] frag_pts;
    logic [WORD_W-1:0] frag_dts;
    logic [WORD_W-1:0] frag_total;
  } ufr_op_t;

endpackage

// ===== rtl/ufr_if.sv =====
// ----------------------------------------------------------------------------
// ufr_if
// Valid/ready channels of the reassembler: datagram bytes in, results out.
// ----------------------------------------------------------------------------
interface ufr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface ufr_result_if;
  logic        valid;
  logic        ready;
  logic        store_write;
  logic [19:0] store_address;
  logic [7:0]  store_data;
  logic        datagram_done;
  logic [2:0]  status;
  logic [20:0] packet_length;
  logic [31:0] presentation_stamp;
  logic [31:0] decode_stamp;

  modport source (output valid, output store_write, output store_address,
                  output store_data, output datagram_done, output status,
                  output packet_length, output presentation_stamp,
                  output decode_stamp, input ready);
  modport sink   (input valid, input store_write, input store_address,
                  input store_data, input datagram_done, input status,
                  input packet_length, input presentation_stamp,
                  input decode_stamp, output ready);
endinterface

// ===== rtl/ufr_front.sv =====
// ----------------------------------------------------------------------------
// ufr_front
// Header parser: counts datagram bytes, checks the magic, collects the
// header fields and tags each byte for the assembler.
// ----------------------------------------------------------------------------
module ufr_front
  import ufr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ufr_byte_if.sink   byte_chan,
  output logic       push_valid,
  input  logic       push_ready,
  output ufr_op_t    push_op
);

  logic [IDX_W-1:0]  byte_index;
  logic              magic_good;
  logic [LEN_W-1:0]  frag_length;
  logic [WORD_W-1:0] frag_pts;
  logic [WORD_W-1:0] frag_dts;
  logic [WORD_W-1:0] frag_total;

  logic [LEN_W-1:0]  frag_length_next;
  logic [WORD_W-1:0] frag_pts_next;
  logic [WORD_W-1:0] frag_dts_next;
  logic [WORD_W-1:0] frag_total_next;
  logic [IDX_W-1:0]  pay_idx;
  logic              accept;

  assign byte_chan.ready = push_ready;
  assign push_valid      = byte_chan.valid;
  assign accept          = byte_chan.valid && push_ready;
  assign pay_idx         = byte_index - HDR_BYTES_IDX;

  always_comb begin
    frag_length_next = frag_length;
    frag_pts_next    = frag_pts;
    frag_dts_next    = frag_dts;
    frag_total_next  = frag_total;
    if (byte_index >= IDX_W'(4) && byte_index < IDX_W'(6)) begin
      frag_length_next = {frag_length[7:0], byte_chan.byte_value};
    end else if (byte_index >= IDX_W'(6) && byte_index < IDX_W'(10)) begin
      frag_pts_next = {frag_pts[23:0], byte_chan.byte_value};
    end else if (byte_index >= IDX_W'(10) && byte_index < IDX_W'(14)) begin
      frag_dts_next = {frag_dts[23:0], byte_chan.byte_value};
    end else if (byte_index >= IDX_W'(14) && byte_index < HDR_BYTES_IDX) begin
      frag_total_next = {frag_total[23:0], byte_chan.byte_value};
    end
  end

  always_comb begin
    push_op.byte_data   = byte_chan.byte_value;
    push_op.last        = byte_chan.last_byte;
    push_op.early       = byte_index < HDR_LAST_IDX;
    push_op.judge       = byte_index == HDR_LAST_IDX;
    push_op.payload     = byte_index >= HDR_BYTES_IDX && byte_index < DGRAM_MAX_IDX &&
                          {{(LEN_W-IDX_W){1'b0}}, pay_idx} < frag_length;
    push_op.offset      = pay_idx;
    push_op.magic_ok    = magic_good;
    push_op.frag_length = frag_length_next;
    push_op.frag_pts    = frag_pts_next;
    push_op.frag_dts    = frag_dts_next;
    push_op.frag_total  = frag_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      magic_good  <= 1'b1;
      frag_length <= '0;
      frag_pts    <= '0;
      frag_dts    <= '0;
      frag_total  <= '0;
    end else if (accept) begin
      frag_length <= frag_length_next;
      frag_pts    <= frag_pts_next;
      frag_dts    <= frag_dts_next;
      frag_total  <= frag_total_next;
      if (byte_index < IDX_W'(4) &&
          byte_chan.byte_value != magic_byte(byte_index[1:0])) begin
        magic_good <= 1'b0;
      end
      if (byte_chan.last_byte) begin
        byte_index <= '0;
        magic_good <= 1'b1;
      end else if (byte_index != INDEX_MAX) begin
        byte_index <= byte_index + IDX_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ufr_queue.sv =====
// ----------------------------------------------------------------------------
// ufr_queue
// Two-entry request queue between the parser and the assembler.
// ----------------------------------------------------------------------------
module ufr_queue
  import ufr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  ufr_op_t push_op,
  output logic    pop_valid,
  input  logic    pop_ready,
  output ufr_op_t pop_op
);

  ufr_op_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_op     = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ufr_back.sv =====
// ----------------------------------------------------------------------------
// ufr_back
// Packet assembler: judges headers against the packet in progress, places
// payload bytes, tracks the fill offset and registers one result per byte.
// ----------------------------------------------------------------------------
module ufr_back
  import ufr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  ufr_op_t      pop_op,
  ufr_result_if.source result_chan
);

  logic [WORD_W-1:0] held_pts;
  logic [WORD_W-1:0] held_dts;
  logic [FILL_W-1:0] held_total;
  logic [FILL_W-1:0] fill_offset;
  logic              payload_accept;
  logic [2:0]        pending_status;

  logic [WORD_W-1:0] held_pts_next;
  logic [WORD_W-1:0] held_dts_next;
  logic [FILL_W-1:0] held_total_next;
  logic [FILL_W-1:0] fill_offset_next;
  logic              payload_accept_next;
  logic [2:0]        pending_status_next;

  logic              wr_next;
  logic [ADDR_W-1:0] addr_next;
  logic [7:0]        data_next;
  logic              done_next;
  logic [2:0]        status_next;
  logic [FILL_W-1:0] length_next;
  logic [WORD_W-1:0] pts_next;
  logic [WORD_W-1:0] dts_next;

  logic [LEN_W:0]    hdr_span;
  logic [FILL_W:0]   fill_end;
  logic              pop;

  assign pop_ready = !result_chan.valid || result_chan.ready;
  assign pop       = pop_valid && pop_ready;
  assign hdr_span  = {1'b0, pop_op.frag_length} + (LEN_W+1)'(HEADER_BYTES);
  assign fill_end  = {1'b0, fill_offset} + (FILL_W+1)'(pop_op.frag_length);

  always_comb begin
    held_pts_next       = held_pts;
    held_dts_next       = held_dts;
    held_total_next     = held_total;
    fill_offset_next    = fill_offset;
    payload_accept_next = payload_accept;
    pending_status_next = pending_status;

    wr_next     = 1'b0;
    addr_next   = '0;
    data_next   = '0;
    done_next   = 1'b0;
    status_next = ST_PARTIAL;
    length_next = '0;
    pts_next    = '0;
    dts_next    = '0;

    if (pop_op.payload && payload_accept) begin
      wr_next   = 1'b1;
      addr_next = fill_offset[ADDR_W-1:0] + ADDR_W'(pop_op.offset);
      data_next = pop_op.byte_data;
    end

    if (pop_op.judge) begin
      payload_accept_next = 1'b0;
      if (!pop_op.magic_ok) begin
        pending_status_next = ST_NOT_FRAG;
      end else if (fill_offset == '0) begin
        if (pop_op.frag_total > WORD_W'(PACKET_BYTES)) begin
          pending_status_next = ST_PKT_OVER;
        end else begin
          held_pts_next   = pop_op.frag_pts;
          held_dts_next   = pop_op.frag_dts;
          held_total_next = pop_op.frag_total[FILL_W-1:0];
          if (hdr_span > (LEN_W+1)'(DATAGRAM_MAX)) begin
            pending_status_next = ST_HDR_OVER;
          end else if (WORD_W'(pop_op.frag_length) > pop_op.frag_total) begin
            pending_status_next = ST_PKT_OVER;
          end else begin
            pending_status_next = ST_PARTIAL;
            payload_accept_next = 1'b1;
          end
        end
      end else if (pop_op.frag_pts != held_pts) begin
        pending_status_next = ST_STAMP_BAD;
        fill_offset_next    = '0;
      end else if (fill_end > {1'b0, held_total}) begin
        pending_status_next = ST_PKT_OVER;
        fill_offset_next    = '0;
      end else begin
        pending_status_next = ST_PARTIAL;
        payload_accept_next = 1'b1;
      end
    end

    // an accepted fragment never has its fill offset cleared by the header check
    if (pop_op.last) begin
      done_next = 1'b1;
      if (pop_op.early) begin
        status_next = ST_NOT_FRAG;
      end else if (payload_accept_next) begin
        if (WORD_W'(fill_end) == pop_op.frag_total) begin
          status_next      = ST_COMPLETE;
          length_next      = held_total_next;
          pts_next         = held_pts_next;
          dts_next         = held_dts_next;
          fill_offset_next = '0;
        end else begin
          status_next      = ST_PARTIAL;
          fill_offset_next = fill_end[FILL_W-1:0];
        end
      end else begin
        status_next = pending_status_next;
      end
      payload_accept_next = 1'b0;
      pending_status_next = ST_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_pts           <= '0;
      held_dts           <= '0;
      held_total         <= '0;
      fill_offset        <= '0;
      payload_accept     <= 1'b0;
      pending_status     <= ST_PARTIAL;
      result_chan.valid  <= 1'b0;
    end else begin
      if (pop) begin
        held_pts          <= held_pts_next;
        held_dts          <= held_dts_next;
        held_total        <= held_total_next;
        fill_offset       <= fill_offset_next;
        payload_accept    <= payload_accept_next;
        pending_status    <= pending_status_next;
        result_chan.valid <= 1'b1;
      end else if (result_chan.ready) begin
        result_chan.valid <= 1'b0;
      end
    end
  end

  // Result payload: load on pop, hold while stalled.
  always_ff @(posedge clk) begin
    if (pop) begin
      result_chan.store_write        <= wr_next;
      result_chan.store_address      <= addr_next;
      result_chan.store_data         <= data_next;
      result_chan.datagram_done      <= done_next;
      result_chan.status             <= status_next;
      result_chan.packet_length      <= length_next;
      result_chan.presentation_stamp <= pts_next;
      result_chan.decode_stamp       <= dts_next;
    end
  end

endmodule

// ===== rtl/udp_fragment_reassembler.sv =====
// ----------------------------------------------------------------------------
// udp_fragment_reassembler
// Rebuilds packets from framed UDP datagrams, one byte per request.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle and returns one result per byte. Each
// accepted byte passes through the two-entry request queue behind the header
// parser and then the assembler's output register before its result appears.
// Payload bytes come out as store writes at the packet fill offset; the
// result for a datagram's last byte carries the status and, when a packet
// completes, its length and stamps. The byte channel stalls only when the
// queue is full, which happens only while the result channel is held off.
module udp_fragment_reassembler
  import ufr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ufr_byte_if.sink     byte_chan,
  ufr_result_if.source result_chan
);

  logic    push_valid;
  logic    push_ready;
  ufr_op_t push_op;
  logic    pop_valid;
  logic    pop_ready;
  ufr_op_t pop_op;

  ufr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_chan  (byte_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  ufr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  ufr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_op      (pop_op),
    .result_chan (result_chan)
  );

endmodule
